// File: rtl/asls_pkg.sv
// ----------------------------------------------------------------------------
// asls_pkg: shared types and constants for the slew-limited ADC smoother
// Field widths, register codes and reset values, the state word of one
// channel, and the sequencer states.
// ----------------------------------------------------------------------------
package asls_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int SAMPLES_DEF  = 10;

  // ADC full-scale code, divisor of the scaling step
  localparam int ADC_FULL = 4095;

  localparam int CH_W    = 3;
  localparam int SMP_W   = 12;
  localparam int SUM_W   = 16;
  localparam int CNT_W   = 4;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 8;
  localparam int VOLT_W  = 23;
  localparam int SUP_W   = 13;
  localparam int GAIN_W  = 16;
  localparam int MILLI_W = 10;

  // mV to uV
  localparam int SCALE_UV = 1000;

  localparam int PROD_W = SUM_W + SUP_W;
  localparam int NUM_W  = PROD_W + MILLI_W + FRAC_W;
  localparam int QUOT_W = VAL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO     = 2'd2;

  localparam logic [SUP_W-1:0]  SUPPLY_RST = 13'd3300;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd9830;
  localparam logic [GAIN_W-1:0] RATIO_RST  = 16'd13107;

  typedef struct packed {
    logic [SUP_W-1:0]  supply_mv;
    logic [GAIN_W-1:0] smoothing_gain;
    logic [GAIN_W-1:0] step_ratio;
  } cfg_t;

  typedef struct packed {
    logic             seeded;
    logic [VAL_W-1:0] filt;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } mem_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [VOLT_W-1:0] voltage_uv;
    logic              was_clamped;
    logic              first_batch;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_LIMIT,
    ST_CLAMP,
    ST_DELTA,
    ST_DONE
  } core_state_e;

endpackage

// File: rtl/asls_if.sv
// ----------------------------------------------------------------------------
// asls_in_if / asls_out_if: valid/ready channels of the smoother
// Sample items in, filtered result items out.
// ----------------------------------------------------------------------------
interface asls_in_if;
  import asls_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface asls_out_if;
  import asls_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_channel;
  logic [VOLT_W-1:0] voltage_uv;
  logic              was_clamped;
  logic              first_batch;

  modport source (output valid, output out_channel, output voltage_uv,
                  output was_clamped, output first_batch, input ready);
  modport sink   (input valid, input out_channel, input voltage_uv,
                  input was_clamped, input first_batch, output ready);
endinterface

// File: rtl/asls_mem.sv
// ----------------------------------------------------------------------------
// asls_mem: per-channel state memory
// One write and one registered read port. Valid bits make an unwritten
// entry read as all zero after reset.
// ----------------------------------------------------------------------------
module asls_mem #(
  parameter int CHANNELS = asls_pkg::CHANNELS_DEF,
  parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output asls_pkg::mem_word_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  asls_pkg::mem_word_t wr_data_i
);
  import asls_pkg::*;

  mem_word_t             mem [CHANNELS];
  logic [CHANNELS-1:0]   vld_q;
  mem_word_t             rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/asls_div.sv
// ----------------------------------------------------------------------------
// asls_div: divider by the batch constant
// Reciprocal multiply gives a quotient estimate at most three low; the
// remainder is then formed and fixed up by compare and subtract.
// The quotient is known to fit QUOT_W bits.
// ----------------------------------------------------------------------------
module asls_div #(
  parameter int SAMPLES = asls_pkg::SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  asls_pkg::div_req_t req_i,
  output asls_pkg::div_rsp_t rsp_o
);
  import asls_pkg::*;

  localparam int DIVISOR = ADC_FULL * SAMPLES;
  localparam int DIV_W   = $clog2(DIVISOR + 1);
  // remainder after the estimate stays below four divisors
  localparam int REM_W   = DIV_W + 2;
  localparam int RCP_SH  = QUOT_W - 1;
  // floor(2^(RCP_SH+DIV_W) / DIVISOR), lies between 2^31 and 2^32
  localparam logic [QUOT_W-1:0] RCP =
    QUOT_W'((64'd1 << (RCP_SH + DIV_W)) / 64'(DIVISOR));
  localparam logic [REM_W-1:0]  DIV_R = REM_W'(DIVISOR);
  localparam logic [QUOT_W-1:0] DIV_Q = QUOT_W'(DIVISOR);

  logic [QUOT_W-1:0]   xs_q, xs_d;
  logic [REM_W-1:0]    xlo_q, xlo_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic                est_q, est_d;
  logic                remv_q, remv_d;
  logic                fix_q, fix_d;
  logic                done_q, done_d;
  logic [2*QUOT_W-1:0] est_full;
  logic [REM_W-1:0]    qd;

  assign est_full = xs_q * RCP;
  // only the low bits matter: the true remainder is small
  assign qd       = REM_W'(quot_q * DIV_Q);

  always_comb begin
    xs_d   = xs_q;
    xlo_d  = xlo_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    est_d  = est_q;
    remv_d = remv_q;
    fix_d  = fix_q;
    done_d = done_q;
    if (req_i.start) begin
      xs_d   = QUOT_W'(req_i.num >> DIV_W);
      xlo_d  = req_i.num[REM_W-1:0];
      est_d  = 1'b1;
      remv_d = 1'b0;
      fix_d  = 1'b0;
      done_d = 1'b0;
    end else if (est_q) begin
      quot_d = est_full[RCP_SH +: QUOT_W];
      est_d  = 1'b0;
      remv_d = 1'b1;
    end else if (remv_q) begin
      rem_d  = xlo_q - qd;
      remv_d = 1'b0;
      fix_d  = 1'b1;
    end else if (fix_q) begin
      if (rem_q >= DIV_R) begin
        rem_d  = rem_q - DIV_R;
        quot_d = quot_q + 1'b1;
      end else begin
        fix_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= 1'b0;
      remv_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      est_q  <= est_d;
      remv_q <= remv_d;
      fix_q  <= fix_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q   <= xs_d;
    xlo_q  <= xlo_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: rtl/asls_core.sv
// ----------------------------------------------------------------------------
// asls_core: sequencer and datapath of the smoother
// Reads a channel's state, accumulates the sample, and at batch end
// scales, limits once seeded, and updates the filtered value before writing back.
// ----------------------------------------------------------------------------
module asls_core #(
  parameter int CHANNELS = asls_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = asls_pkg::SAMPLES_DEF,
  parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  asls_in_if.sink             in_i,
  input  asls_pkg::cfg_t      cfg_i,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  asls_pkg::mem_word_t rd_data_i,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output asls_pkg::mem_word_t wr_data_o,
  output asls_pkg::div_req_t  div_req_o,
  input  asls_pkg::div_rsp_t  div_rsp_i,
  input  logic                res_free_i,
  output logic                res_valid_o,
  output asls_pkg::res_t      res_o
);
  import asls_pkg::*;

  localparam int LIM_W = GAIN_W + VAL_W;

  core_state_e state_q, state_d;

  logic [CH_W-1:0]   ch_q;
  logic [SMP_W-1:0]  smp_q;
  logic [SUM_W-1:0]  sum_q;
  logic [VAL_W-1:0]  f_q;
  logic              seeded_q;
  logic [PROD_W-1:0] prod_q;
  logic              up_q;
  logic [VAL_W-1:0]  mag_q;
  logic [VAL_W-1:0]  limit_q;
  logic [VAL_W-1:0]  delta_q;
  logic              clamped_q;
  logic              first_q;

  logic              accept;
  logic              ch_ok;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic              batch_end;
  logic [VAL_W-1:0]  vin;
  logic [LIM_W-1:0]  lim_full;
  logic [LIM_W-1:0]  dlt_full;
  logic [VAL_W-1:0]  f_new;
  logic [PROD_W+MILLI_W-1:0] milli;

  assign accept    = in_i.valid && in_i.ready;
  assign ch_ok     = 32'(in_i.channel) < CHANNELS;
  assign sum_new   = rd_data_i.sum + SUM_W'(smp_q);
  assign cnt_new   = rd_data_i.cnt + 1'b1;
  assign batch_end = !(32'(cnt_new) < SAMPLES);
  assign vin       = div_rsp_i.quot;
  assign lim_full  = cfg_i.step_ratio * f_q;
  assign dlt_full  = cfg_i.smoothing_gain * mag_q;
  assign milli     = prod_q * MILLI_W'(SCALE_UV);

  always_comb begin
    if (first_q) begin
      f_new = f_q;
    end else if (up_q) begin
      f_new = f_q + delta_q;
    end else begin
      f_new = f_q - delta_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && ch_ok) state_d = ST_READ;
      ST_READ:  state_d = batch_end ? ST_MUL1 : ST_IDLE;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_DIV;
      ST_DIV:   if (div_rsp_i.done) state_d = ST_LIMIT;
      ST_LIMIT: state_d = seeded_q ? ST_CLAMP : ST_DONE;
      ST_CLAMP: state_d = ST_DELTA;
      ST_DELTA: state_d = ST_DONE;
      ST_DONE:  if (res_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready      = 1'b0;
    rd_en_o         = 1'b0;
    wr_en_o         = 1'b0;
    wr_data_o       = '0;
    div_req_o.start = 1'b0;
    res_valid_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        rd_en_o    = accept && ch_ok;
      end
      ST_READ: begin
        if (!batch_end) begin
          wr_en_o          = 1'b1;
          wr_data_o.seeded = rd_data_i.seeded;
          wr_data_o.filt   = rd_data_i.filt;
          wr_data_o.cnt    = cnt_new;
          wr_data_o.sum    = sum_new;
        end
      end
      ST_MUL2: div_req_o.start = 1'b1;
      ST_DONE: begin
        if (res_free_i) begin
          wr_en_o          = 1'b1;
          wr_data_o.seeded = 1'b1;
          wr_data_o.filt   = f_new;
          res_valid_o      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rd_addr_o      = AW'(in_i.channel);
  assign wr_addr_o      = AW'(ch_q);
  assign div_req_o.num  = {milli, {FRAC_W{1'b0}}};

  assign res_o.out_channel = ch_q;
  assign res_o.voltage_uv  = f_new[FRAC_W +: VOLT_W];
  assign res_o.was_clamped = clamped_q;
  assign res_o.first_batch = first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        ch_q  <= in_i.channel;
        smp_q <= in_i.sample;
      end
      ST_READ: begin
        sum_q    <= sum_new;
        f_q      <= rd_data_i.filt;
        seeded_q <= rd_data_i.seeded;
      end
      ST_MUL1: prod_q <= sum_q * cfg_i.supply_mv;
      ST_LIMIT: begin
        clamped_q <= 1'b0;
        if (!seeded_q) begin
          f_q     <= vin;
          first_q <= 1'b1;
        end else begin
          first_q <= 1'b0;
          up_q    <= vin > f_q;
          mag_q   <= (vin > f_q) ? (vin - f_q) : (f_q - vin);
          limit_q <= lim_full[LIM_W-1:GAIN_W];
        end
      end
      ST_CLAMP: begin
        if (mag_q > limit_q) begin
          mag_q     <= limit_q;
          clamped_q <= 1'b1;
        end
      end
      ST_DELTA: delta_q <= dlt_full[LIM_W-1:GAIN_W];
      default: ;
    endcase
  end

endmodule

// File: rtl/adc_slew_limited_smoother.sv
// ----------------------------------------------------------------------------
// adc_slew_limited_smoother: batch-averaged, slew-limited ADC smoother
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   channel, sample
//   out_o    out  valid/ready   out_channel, voltage_uv, was_clamped,
//                               first_batch
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// A sample that does not end a batch is accepted, then the channel entry is
// read, modified and written back. A batch-ending sample also passes the
// multiply, a reciprocal-multiply divide with up to three correction steps,
// and the limit and update steps; a seeding batch skips the clamp and step.
// Unknown channels are accepted and dropped.
// Reset clears the valid bits of the state memory at once; no sweep.
// A finished item sits in the output register while the next sample is
// taken; a batch end finding that register full waits for it to drain.
// ----------------------------------------------------------------------------
module adc_slew_limited_smoother #(
  parameter int CHANNELS = asls_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = asls_pkg::SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  asls_in_if.sink                             in_i,
  asls_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [asls_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [asls_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import asls_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t      cfg_q;
  logic      rd_en;
  logic [AW-1:0] rd_addr;
  mem_word_t rd_data;
  logic      wr_en;
  logic [AW-1:0] wr_addr;
  mem_word_t wr_data;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      res_free;
  logic      res_valid;
  res_t      res;
  res_t      out_q;
  logic      out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.supply_mv      <= SUPPLY_RST;
      cfg_q.smoothing_gain <= GAIN_RST;
      cfg_q.step_ratio     <= RATIO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUPPLY_MV:      cfg_q.supply_mv      <= cfg_wdata_i[SUP_W-1:0];
        CFG_SMOOTHING_GAIN: cfg_q.smoothing_gain <= cfg_wdata_i;
        CFG_STEP_RATIO:     cfg_q.step_ratio     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  asls_mem #(.CHANNELS(CHANNELS), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  asls_div #(.SAMPLES(SAMPLES)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  asls_core #(.CHANNELS(CHANNELS), .SAMPLES(SAMPLES), .AW(AW)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign res_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_free) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_channel = out_q.out_channel;
  assign out_o.voltage_uv  = out_q.voltage_uv;
  assign out_o.was_clamped = out_q.was_clamped;
  assign out_o.first_batch = out_q.first_batch;

endmodule

// File: rtl/asls_checker.sv
// ----------------------------------------------------------------------------
// asls_checker: port-level checks for the smoother
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module asls_checker #(
  parameter int CHANNELS = asls_pkg::CHANNELS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [asls_pkg::CH_W-1:0]   in_channel_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [asls_pkg::CH_W-1:0]   out_channel_i,
  input logic [asls_pkg::VOLT_W-1:0] voltage_uv_i,
  input logic                        was_clamped_i,
  input logic                        first_batch_i
);
  import asls_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_channel_i)
      && $stable(voltage_uv_i) && $stable(was_clamped_i) && $stable(first_batch_i))
    else $error("stalled result changed");

  // seeding never clamps
  a_seed_noclamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && first_batch_i |-> !was_clamped_i)
    else $error("seeding item reports clamp");

  a_out_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(out_channel_i) < CHANNELS)
    else $error("result on absent channel");

  // a known-channel sample drops ready while the sequencer is busy with it
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (32'(in_channel_i) < CHANNELS) |=> !in_ready_i)
    else $error("input taken while sample in flight");

endmodule

bind adc_slew_limited_smoother asls_checker #(.CHANNELS(CHANNELS)) u_asls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_channel_i  (in_i.channel),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.out_channel),
  .voltage_uv_i  (out_o.voltage_uv),
  .was_clamped_i (out_o.was_clamped),
  .first_batch_i (out_o.first_batch)
);
